### hw/rtl/psfrl_pkg.sv
package psfrl_pkg;

   localparam int ADDR_W      = 32;
   localparam int TIME_W      = 32;
   localparam int OP_W        = 2;
   localparam int MS_W        = 27;
   localparam int THR_W       = 8;
   localparam int CNT_W       = 8;
   localparam int TRK_W       = 4;
   localparam int BLK_W       = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 27;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [OP_W-1:0] OP_CHECK   = 2'd0;
   localparam logic [OP_W-1:0] OP_FAILURE = 2'd1;
   localparam logic [OP_W-1:0] OP_SUCCESS = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_MS      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_THRESHOLD  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_BLOCK_MS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_BLOCK_MS   = 3'd4;

   localparam logic [BLK_W-1:0] BLOCK_NONE  = 2'd0;
   localparam logic [BLK_W-1:0] BLOCK_SHORT = 2'd1;
   localparam logic [BLK_W-1:0] BLOCK_LONG  = 2'd2;

   localparam logic [CNT_W-1:0]  CNT_MAX        = 8'hFF;
   localparam logic [TIME_W-1:0] TIME_MAX_STAMP = 32'hFFFF_FFFF;
   localparam logic [TRK_W-1:0]  TRK_MAX        = 4'd15;

   localparam logic [MS_W-1:0]  RST_WINDOW_MS       = 27'd300000;
   localparam logic [THR_W-1:0] RST_SHORT_THRESHOLD = 8'd5;
   localparam logic [THR_W-1:0] RST_LONG_THRESHOLD  = 8'd10;
   localparam logic [MS_W-1:0]  RST_SHORT_BLOCK_MS  = 27'd60000;
   localparam logic [MS_W-1:0]  RST_LONG_BLOCK_MS   = 27'd300000;

   typedef enum logic [1:0] {
      CMD_NOP,
      CMD_CHECK,
      CMD_FAILURE,
      CMD_SUCCESS
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [ADDR_W-1:0]   addr;
      logic [TIME_W-1:0]   now;
   } cmd_type;

   typedef struct packed {
      logic [MS_W-1:0]  window_ms;
      logic [THR_W-1:0] short_threshold;
      logic [THR_W-1:0] long_threshold;
      logic [MS_W-1:0]  short_block_ms;
      logic [MS_W-1:0]  long_block_ms;
   } cfg_type;

endpackage

### hw/rtl/per_source_failure_rate_limiter.sv
// Tracks failed attempts per source address in a table of SLOTS entries and
// answers each transaction with exactly one result, shown on the rsp_ ports
// for a single cycle with rsp_valid high; the receiver cannot stall, so it
// must take every result in that cycle. A start while busy is low is taken
// into a two-entry queue; busy rises only while that queue is full. The
// engine behind the queue runs a check or success for an address with a
// slot through FIND, READ and EXEC, a failure through FIND, READ, EXEC and
// ARM, and a failure for a new address that finds the table full through
// EVICT too, scanning every slot for the oldest last failure. A
// transaction with address zero or an unused op code, or a check or success
// for an address with no slot, ends after FIND. Results come back in order.
// Configuration registers are written through the csr_ port, which is always
// ready, and are to be changed only while no transaction is outstanding.
module per_source_failure_rate_limiter #(
   parameter int SLOTS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [psfrl_pkg::OP_W-1:0]          req_op,
   input  logic [psfrl_pkg::ADDR_W-1:0]        req_source_addr,
   input  logic [psfrl_pkg::TIME_W-1:0]        req_now_ms,
   output logic                                rsp_valid,
   output logic                                rsp_allowed,
   output logic [psfrl_pkg::BLK_W-1:0]         rsp_block_set,
   output logic                                rsp_evicted,
   output logic [psfrl_pkg::TRK_W-1:0]         rsp_tracked_count,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [psfrl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [psfrl_pkg::CSR_DATA_W-1:0]    csr_data
);

   psfrl_pkg::cfg_type cfg_ff, cfg_in;
   psfrl_pkg::cmd_type push_cmd, head_cmd;
   logic               q_full, q_push, q_pop, head_valid;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            psfrl_pkg::CSR_WINDOW_MS: begin
               cfg_in.window_ms = csr_data[psfrl_pkg::MS_W-1:0];
            end
            psfrl_pkg::CSR_SHORT_THRESHOLD: begin
               cfg_in.short_threshold = csr_data[psfrl_pkg::THR_W-1:0];
            end
            psfrl_pkg::CSR_LONG_THRESHOLD: begin
               cfg_in.long_threshold = csr_data[psfrl_pkg::THR_W-1:0];
            end
            psfrl_pkg::CSR_SHORT_BLOCK_MS: begin
               cfg_in.short_block_ms = csr_data[psfrl_pkg::MS_W-1:0];
            end
            psfrl_pkg::CSR_LONG_BLOCK_MS: begin
               cfg_in.long_block_ms = csr_data[psfrl_pkg::MS_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_ms       <= psfrl_pkg::RST_WINDOW_MS;
         cfg_ff.short_threshold <= psfrl_pkg::RST_SHORT_THRESHOLD;
         cfg_ff.long_threshold  <= psfrl_pkg::RST_LONG_THRESHOLD;
         cfg_ff.short_block_ms  <= psfrl_pkg::RST_SHORT_BLOCK_MS;
         cfg_ff.long_block_ms   <= psfrl_pkg::RST_LONG_BLOCK_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   psfrl_front u_front (
      .start       (start),
      .op          (req_op),
      .source_addr (req_source_addr),
      .now_ms      (req_now_ms),
      .q_full      (q_full),
      .busy        (busy),
      .q_push      (q_push),
      .q_cmd       (push_cmd)
   );

   psfrl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (push_cmd),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   psfrl_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .q_valid           (head_valid),
      .q_cmd             (head_cmd),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_allowed       (rsp_allowed),
      .rsp_block_set     (rsp_block_set),
      .rsp_evicted       (rsp_evicted),
      .rsp_tracked_count (rsp_tracked_count)
   );

endmodule

### hw/rtl/psfrl_front.sv
module psfrl_front (
   input  logic                           start,
   input  logic [psfrl_pkg::OP_W-1:0]     op,
   input  logic [psfrl_pkg::ADDR_W-1:0]   source_addr,
   input  logic [psfrl_pkg::TIME_W-1:0]   now_ms,
   input  logic                           q_full,
   output logic                           busy,
   output logic                           q_push,
   output psfrl_pkg::cmd_type             q_cmd
);

   logic addr_zero;

   assign addr_zero = (source_addr == '0);
   assign busy      = q_full;
   assign q_push    = start && !q_full;

   // address zero is never tracked, unused codes do nothing
   always_comb begin
      q_cmd.addr = source_addr;
      q_cmd.now  = now_ms;
      unique case (op)
         psfrl_pkg::OP_CHECK: begin
            q_cmd.kind = addr_zero ? psfrl_pkg::CMD_NOP : psfrl_pkg::CMD_CHECK;
         end
         psfrl_pkg::OP_FAILURE: begin
            q_cmd.kind = addr_zero ? psfrl_pkg::CMD_NOP : psfrl_pkg::CMD_FAILURE;
         end
         psfrl_pkg::OP_SUCCESS: begin
            q_cmd.kind = addr_zero ? psfrl_pkg::CMD_NOP : psfrl_pkg::CMD_SUCCESS;
         end
         default: begin
            q_cmd.kind = psfrl_pkg::CMD_NOP;
         end
      endcase
   end

endmodule

### hw/rtl/psfrl_queue.sv
module psfrl_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  psfrl_pkg::cmd_type  push_cmd,
   input  logic                pop,
   output logic                full,
   output logic                head_valid,
   output psfrl_pkg::cmd_type  head_cmd
);

   localparam int QD  = psfrl_pkg::QUEUE_DEPTH;
   localparam int QAW = (QD > 1) ? $clog2(QD) : 1;
   localparam int QCW = $clog2(QD + 1);

   psfrl_pkg::cmd_type mem_ff [QD];
   logic [QAW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0] count_ff, count_in;
   logic           do_push, do_pop;

   assign full       = (count_ff == QCW'(QD));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QAW'(QD - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QAW'(QD - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### hw/rtl/psfrl_back.sv
module psfrl_back #(
   parameter int SLOTS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  psfrl_pkg::cfg_type              cfg,
   input  logic                            q_valid,
   input  psfrl_pkg::cmd_type              q_cmd,
   output logic                            q_pop,
   output logic                            rsp_valid,
   output logic                            rsp_allowed,
   output logic [psfrl_pkg::BLK_W-1:0]     rsp_block_set,
   output logic                            rsp_evicted,
   output logic [psfrl_pkg::TRK_W-1:0]     rsp_tracked_count
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int AW = psfrl_pkg::ADDR_W;
   localparam int TW = psfrl_pkg::TIME_W;
   localparam int NW = psfrl_pkg::CNT_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_EVICT,
      ST_READ,
      ST_EXEC,
      ST_ARM
   } state_type;

   // slot table
   logic [AW-1:0] slot_addr_ff       [SLOTS];
   logic [NW-1:0] slot_fail_count_ff [SLOTS];
   logic [TW-1:0] slot_first_fail_ff [SLOTS];
   logic [TW-1:0] slot_last_fail_ff  [SLOTS];
   logic [TW-1:0] slot_block_until_ff[SLOTS];

   state_type          state_ff, state_in;
   psfrl_pkg::cmd_type cmd_ff, cmd_in;
   logic [IW-1:0]      sel_ff, sel_in;
   logic               hit_ff, hit_in;
   logic               evict_ff, evict_in;
   logic               inc_ff, inc_in;
   logic [IW-1:0]      scan_ff, scan_in;
   logic [IW-1:0]      pick_ff, pick_in;
   logic [TW-1:0]      best_ff, best_in;
   logic [NW-1:0]      cur_cnt_ff, cur_cnt_in;
   logic [TW-1:0]      cur_first_ff, cur_first_in;
   logic [TW-1:0]      cur_bu_ff, cur_bu_in;
   logic [NW-1:0]      ncnt_ff, ncnt_in;
   logic [TW-1:0]      nfirst_ff, nfirst_in;
   logic [CW-1:0]      tracked_ff, tracked_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_allowed_ff, rsp_allowed_in;
   logic [psfrl_pkg::BLK_W-1:0] rsp_block_ff, rsp_block_in;
   logic               rsp_evicted_ff, rsp_evicted_in;
   logic [psfrl_pkg::TRK_W-1:0] rsp_tracked_ff, rsp_tracked_in;

   logic               hit, any_free;
   logic [IW-1:0]      match_idx, free_idx;
   logic               better;
   logic [TW-1:0]      bu_diff, age;
   logic               expired;
   logic [NW-1:0]      c0;

   logic               wr_en;
   logic [IW-1:0]      wr_idx;
   logic [AW-1:0]      wr_addr;
   logic [NW-1:0]      wr_cnt;
   logic [TW-1:0]      wr_first, wr_last, wr_bu;

   function automatic logic [psfrl_pkg::TRK_W-1:0] sat_trk(input logic [CW-1:0] n);
      if (32'(n) > 32'(psfrl_pkg::TRK_MAX)) begin
         return psfrl_pkg::TRK_MAX;
      end
      return psfrl_pkg::TRK_W'(n);
   endfunction

   // lowest matching slot and lowest free slot
   always_comb begin
      hit       = 1'b0;
      any_free  = 1'b0;
      match_idx = '0;
      free_idx  = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (slot_fail_count_ff[i] != '0 && slot_addr_ff[i] == cmd_ff.addr) begin
            hit       = 1'b1;
            match_idx = IW'(i);
         end
         if (slot_fail_count_ff[i] == '0) begin
            any_free = 1'b1;
            free_idx = IW'(i);
         end
      end
   end

   assign better  = (slot_last_fail_ff[scan_ff] < best_ff);
   assign bu_diff = cmd_ff.now - cur_bu_ff;
   assign age     = cmd_ff.now - cur_first_ff;
   assign expired = (cur_cnt_ff != '0) && (age > TW'(cfg.window_ms));
   assign c0      = expired ? '0 : cur_cnt_ff;

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      sel_in         = sel_ff;
      hit_in         = hit_ff;
      evict_in       = evict_ff;
      inc_in         = inc_ff;
      scan_in        = scan_ff;
      pick_in        = pick_ff;
      best_in        = best_ff;
      cur_cnt_in     = cur_cnt_ff;
      cur_first_in   = cur_first_ff;
      cur_bu_in      = cur_bu_ff;
      ncnt_in        = ncnt_ff;
      nfirst_in      = nfirst_ff;
      tracked_in     = tracked_ff;
      rsp_valid_in   = 1'b0;
      rsp_allowed_in = 1'b1;
      rsp_block_in   = psfrl_pkg::BLOCK_NONE;
      rsp_evicted_in = 1'b0;
      rsp_tracked_in = rsp_tracked_ff;
      q_pop          = 1'b0;
      wr_en          = 1'b0;
      wr_idx         = sel_ff;
      wr_addr        = cmd_ff.addr;
      wr_cnt         = '0;
      wr_first       = '0;
      wr_last        = '0;
      wr_bu          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_cmd;
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            hit_in   = hit;
            evict_in = 1'b0;
            inc_in   = 1'b0;
            sel_in   = hit ? match_idx : free_idx;
            if (cmd_ff.kind == psfrl_pkg::CMD_FAILURE) begin
               if (hit || any_free) begin
                  inc_in   = !hit;
                  state_in = ST_READ;
               end else begin
                  scan_in  = '0;
                  pick_in  = '0;
                  best_in  = psfrl_pkg::TIME_MAX_STAMP;
                  state_in = ST_EVICT;
               end
            end else if (cmd_ff.kind != psfrl_pkg::CMD_NOP && hit) begin
               state_in = ST_READ;
            end else begin
               rsp_valid_in   = 1'b1;
               rsp_tracked_in = sat_trk(tracked_ff);
               state_in       = ST_IDLE;
            end
         end
         ST_EVICT: begin
            if (better) begin
               best_in = slot_last_fail_ff[scan_ff];
               pick_in = scan_ff;
            end
            if (scan_ff == IW'(SLOTS - 1)) begin
               sel_in   = better ? scan_ff : pick_ff;
               evict_in = 1'b1;
               state_in = ST_READ;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_READ: begin
            if (hit_ff) begin
               cur_cnt_in   = slot_fail_count_ff[sel_ff];
               cur_first_in = slot_first_fail_ff[sel_ff];
               cur_bu_in    = slot_block_until_ff[sel_ff];
            end else begin
               cur_cnt_in   = '0;
               cur_first_in = '0;
               cur_bu_in    = '0;
            end
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (cmd_ff.kind)
               psfrl_pkg::CMD_FAILURE: begin
                  nfirst_in = (c0 == '0) ? cmd_ff.now : cur_first_ff;
                  ncnt_in   = (c0 == psfrl_pkg::CNT_MAX) ? psfrl_pkg::CNT_MAX : c0 + 1'b1;
                  state_in  = ST_ARM;
               end
               psfrl_pkg::CMD_SUCCESS: begin
                  wr_en          = 1'b1;
                  wr_addr        = '0;
                  tracked_in     = tracked_ff - 1'b1;
                  rsp_valid_in   = 1'b1;
                  rsp_tracked_in = sat_trk(tracked_in);
                  state_in       = ST_IDLE;
               end
               default: begin
                  if (cur_bu_ff != '0 && bu_diff[TW-1]) begin
                     rsp_allowed_in = 1'b0;
                  end else if (cur_bu_ff != '0 || expired) begin
                     wr_en      = 1'b1;
                     tracked_in = tracked_ff - 1'b1;
                  end
                  rsp_valid_in   = 1'b1;
                  rsp_tracked_in = sat_trk(tracked_in);
                  state_in       = ST_IDLE;
               end
            endcase
         end
         ST_ARM: begin
            wr_en    = 1'b1;
            wr_cnt   = ncnt_ff;
            wr_first = nfirst_ff;
            wr_last  = cmd_ff.now;
            wr_bu    = cur_bu_ff;
            if (ncnt_ff >= cfg.long_threshold) begin
               wr_bu        = cmd_ff.now + TW'(cfg.long_block_ms);
               rsp_block_in = psfrl_pkg::BLOCK_LONG;
            end else if (ncnt_ff >= cfg.short_threshold) begin
               wr_bu        = cmd_ff.now + TW'(cfg.short_block_ms);
               rsp_block_in = psfrl_pkg::BLOCK_SHORT;
            end
            if (inc_ff) begin
               tracked_in = tracked_ff + 1'b1;
            end
            rsp_valid_in   = 1'b1;
            rsp_evicted_in = evict_ff;
            rsp_tracked_in = sat_trk(tracked_in);
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         tracked_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
         rsp_allowed_ff <= 1'b1;
         rsp_block_ff   <= psfrl_pkg::BLOCK_NONE;
         rsp_evicted_ff <= 1'b0;
         rsp_tracked_ff <= '0;
      end else begin
         state_ff       <= state_in;
         tracked_ff     <= tracked_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_allowed_ff <= rsp_allowed_in;
         rsp_block_ff   <= rsp_block_in;
         rsp_evicted_ff <= rsp_evicted_in;
         rsp_tracked_ff <= rsp_tracked_in;
      end
      cmd_ff       <= cmd_in;
      sel_ff       <= sel_in;
      hit_ff       <= hit_in;
      evict_ff     <= evict_in;
      inc_ff       <= inc_in;
      scan_ff      <= scan_in;
      pick_ff      <= pick_in;
      best_ff      <= best_in;
      cur_cnt_ff   <= cur_cnt_in;
      cur_first_ff <= cur_first_in;
      cur_bu_ff    <= cur_bu_in;
      ncnt_ff      <= ncnt_in;
      nfirst_ff    <= nfirst_in;
   end

   // a zero failure count marks a free slot
   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOTS; i++) begin
         if (reset) begin
            slot_fail_count_ff[i] <= '0;
         end else if (wr_en && wr_idx == IW'(i)) begin
            slot_fail_count_ff[i] <= wr_cnt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_addr_ff[wr_idx]        <= wr_addr;
         slot_first_fail_ff[wr_idx]  <= wr_first;
         slot_last_fail_ff[wr_idx]   <= wr_last;
         slot_block_until_ff[wr_idx] <= wr_bu;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_allowed       = rsp_allowed_ff;
   assign rsp_block_set     = rsp_block_ff;
   assign rsp_evicted       = rsp_evicted_ff;
   assign rsp_tracked_count = rsp_tracked_ff;

endmodule
